// ===== rtl/core/s2i_pkg.sv =====
// Shared types and constants for the string to integer parser.
// No dependencies; the files that use it refer to it by scoped names.
package s2i_pkg;

    localparam logic [2:0] PH_DONE   = 3'd0;
    localparam logic [2:0] PH_SPACE  = 3'd1;
    localparam logic [2:0] PH_SIGNED = 3'd2;
    localparam logic [2:0] PH_ZERO   = 3'd3;
    localparam logic [2:0] PH_XPFX   = 3'd4;
    localparam logic [2:0] PH_DIGITS = 3'd5;

    localparam logic [1:0] DS_NONE  = 2'd0;
    localparam logic [1:0] DS_TAKEN = 2'd1;
    localparam logic [1:0] DS_OVER  = 2'd2;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_ONE  = 6'd1;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_HEX  = 6'd16;
    localparam logic [5:0] BASE_MAX  = 6'd36;

    localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [2:0]  phase;
        logic [63:0] acc;
        logic        neg;
        logic [1:0]  dstat;
        logic [5:0]  base;
    } state_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic               overflow;
        logic               converted;
        logic [7:0]         end_offset;
    } result_t;

endpackage

// ===== rtl/core/s2i_if.sv =====
// Valid/ready channel interfaces for the parser's character and result words.
// No dependencies.
interface s2i_in_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [5:0] radix;
    logic [7:0] ch;

    modport source (output valid, start_req, radix, ch, input ready);
    modport sink (input valid, start_req, radix, ch, output ready);
endinterface

interface s2i_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic               overflow;
    logic               converted;
    logic [7:0]         end_offset;

    modport source (output valid, value, overflow, converted, end_offset, input ready);
    modport sink (input valid, value, overflow, converted, end_offset, output ready);
endinterface

// ===== rtl/core/s2i_mac.sv =====
// Digit accumulate: acc * base + digit with sticky overflow detection.
// Depends on s2i_pkg.
module s2i_mac
(
    input  logic [63:0] acc,
    input  logic [5:0]  base,
    input  logic [5:0]  digit,
    input  logic        neg,
    input  logic [1:0]  dstat,
    output logic [63:0] acc_next,
    output logic [1:0]  dstat_next
);

    logic [69:0] prod;
    logic [69:0] sum;
    logic [63:0] limit;
    logic        over;

    always_comb
    begin
        prod = '0;
        for (int i = 0; i < 6; i++)
        begin
            if (base[i])
            begin
                prod = prod + (70'(acc) << i);
            end
        end
    end

    assign sum   = prod + 70'(digit);
    assign limit = neg ? s2i_pkg::VAL_MIN : s2i_pkg::VAL_MAX;
    assign over  = sum > 70'(limit);

    always_comb
    begin
        acc_next   = acc;
        dstat_next = dstat;
        if (dstat != s2i_pkg::DS_OVER)
        begin
            if (over)
            begin
                dstat_next = s2i_pkg::DS_OVER;
            end
            else
            begin
                acc_next   = sum[63:0];
                dstat_next = s2i_pkg::DS_TAKEN;
            end
        end
    end

endmodule

// ===== rtl/core/s2i_step.sv =====
// Per-character parse step: phase decode, prefix and sign handling, result build.
// Depends on s2i_pkg and s2i_mac.
module s2i_step
#(
    parameter int MAX_OFFSET = 255,
    localparam int POS_W = $clog2(MAX_OFFSET + 1)
)
(
    input  logic                   start_req,
    input  logic [5:0]             radix,
    input  logic [7:0]             ch,
    input  s2i_pkg::state_t        st,
    input  logic [POS_W-1:0]       pos,
    output s2i_pkg::state_t        st_next,
    output logic [POS_W-1:0]       pos_next,
    output logic                   emit,
    output s2i_pkg::result_t       res
);

    localparam int OW = (POS_W > 8) ? POS_W : 8;

    s2i_pkg::state_t  s;
    logic [POS_W-1:0] p;
    logic             is_dig;
    logic [5:0]       dig;
    logic [5:0]       base_eff;
    logic             dig_ok;
    logic [63:0]      mac_acc;
    logic [1:0]       mac_ds;
    logic             conv;
    logic [OW-1:0]    off_w;
    logic             do_first;
    logic             bad;

    always_comb
    begin
        is_dig = 1'b1;
        dig    = '0;
        if (ch >= s2i_pkg::CH_ZERO && ch <= s2i_pkg::CH_NINE)
        begin
            dig = 6'(ch - s2i_pkg::CH_ZERO);
        end
        else if (ch >= s2i_pkg::CH_UA && ch <= s2i_pkg::CH_UZ)
        begin
            dig = 6'(ch - s2i_pkg::CH_UA + 8'd10);
        end
        else if (ch >= s2i_pkg::CH_LA && ch <= s2i_pkg::CH_LZ)
        begin
            dig = 6'(ch - s2i_pkg::CH_LA + 8'd10);
        end
        else
        begin
            is_dig = 1'b0;
        end
    end

    always_comb
    begin
        if (start_req)
        begin
            s.phase = s2i_pkg::PH_SPACE;
            s.acc   = '0;
            s.neg   = 1'b0;
            s.dstat = s2i_pkg::DS_NONE;
            s.base  = radix;
            p       = '0;
        end
        else
        begin
            s = st;
            p = pos;
        end
    end

    assign bad = start_req && (radix == s2i_pkg::BASE_ONE || radix > s2i_pkg::BASE_MAX);

    always_comb
    begin
        if (s.base != s2i_pkg::BASE_AUTO)
        begin
            base_eff = s.base;
        end
        else if (s.phase == s2i_pkg::PH_ZERO)
        begin
            base_eff = s2i_pkg::BASE_OCT;
        end
        else
        begin
            base_eff = s2i_pkg::BASE_DEC;
        end
    end

    assign dig_ok = is_dig && (dig < base_eff);

    s2i_mac u_mac
    (
        .acc        (s.acc),
        .base       (base_eff),
        .digit      (dig),
        .neg        (s.neg),
        .dstat      (s.dstat),
        .acc_next   (mac_acc),
        .dstat_next (mac_ds)
    );

    always_comb
    begin
        st_next  = s;
        pos_next = p;
        emit     = 1'b0;
        conv     = 1'b0;
        off_w    = '0;
        do_first = 1'b0;

        if (bad)
        begin
            emit          = 1'b1;
            st_next.phase = s2i_pkg::PH_DONE;
        end
        else
        begin
            case (s.phase)
                s2i_pkg::PH_SPACE:
                begin
                    if (ch == s2i_pkg::CH_SPACE || ch == s2i_pkg::CH_TAB)
                    begin
                        st_next = s;
                    end
                    else if (ch == s2i_pkg::CH_PLUS || ch == s2i_pkg::CH_MINUS)
                    begin
                        st_next.neg   = (ch == s2i_pkg::CH_MINUS);
                        st_next.phase = s2i_pkg::PH_SIGNED;
                    end
                    else
                    begin
                        do_first = 1'b1;
                    end
                end
                s2i_pkg::PH_SIGNED:
                begin
                    do_first = 1'b1;
                end
                s2i_pkg::PH_ZERO:
                begin
                    if ((s.base == s2i_pkg::BASE_AUTO || s.base == s2i_pkg::BASE_HEX) &&
                        (ch == s2i_pkg::CH_LX || ch == s2i_pkg::CH_UX))
                    begin
                        st_next.base  = s2i_pkg::BASE_HEX;
                        st_next.phase = s2i_pkg::PH_XPFX;
                    end
                    else
                    begin
                        st_next.base = base_eff;
                        if (dig_ok)
                        begin
                            st_next.acc   = mac_acc;
                            st_next.dstat = mac_ds;
                            st_next.phase = s2i_pkg::PH_DIGITS;
                        end
                        else
                        begin
                            emit  = 1'b1;
                            conv  = 1'b1;
                            off_w = OW'(p);
                        end
                    end
                end
                s2i_pkg::PH_XPFX:
                begin
                    if (dig_ok)
                    begin
                        st_next.acc   = mac_acc;
                        st_next.dstat = mac_ds;
                        st_next.phase = s2i_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        emit  = 1'b1;
                        conv  = 1'b1;
                        off_w = (p != '0) ? OW'(p - 1'b1) : '0;
                    end
                end
                s2i_pkg::PH_DIGITS:
                begin
                    if (dig_ok)
                    begin
                        st_next.acc   = mac_acc;
                        st_next.dstat = mac_ds;
                    end
                    else
                    begin
                        emit  = 1'b1;
                        conv  = 1'b1;
                        off_w = OW'(p);
                    end
                end
                default:
                begin
                    st_next = s;
                end
            endcase

            if (do_first)
            begin
                if (ch == s2i_pkg::CH_ZERO)
                begin
                    st_next.acc   = '0;
                    st_next.dstat = s2i_pkg::DS_TAKEN;
                    st_next.phase = s2i_pkg::PH_ZERO;
                end
                else
                begin
                    st_next.base = base_eff;
                    if (dig_ok)
                    begin
                        st_next.acc   = mac_acc;
                        st_next.dstat = mac_ds;
                        st_next.phase = s2i_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
            end

            if (emit)
            begin
                st_next.phase = s2i_pkg::PH_DONE;
            end

            if (s.phase != s2i_pkg::PH_DONE && p < POS_W'(MAX_OFFSET))
            begin
                pos_next = p + 1'b1;
            end
        end
    end

    always_comb
    begin
        res.converted  = conv;
        res.overflow   = conv && (s.dstat == s2i_pkg::DS_OVER);
        res.end_offset = (off_w > OW'(255)) ? 8'hFF : off_w[7:0];
        if (!conv)
        begin
            res.value = '0;
        end
        else if (s.dstat == s2i_pkg::DS_OVER)
        begin
            res.value = s.neg ? s2i_pkg::VAL_MIN : s2i_pkg::VAL_MAX;
        end
        else
        begin
            res.value = s.neg ? (64'd0 - s.acc) : s.acc;
        end
    end

endmodule

// ===== rtl/core/string_to_integer_parser.sv =====
// Top level of the strtol-style string to integer parser.
// Depends on s2i_pkg, s2i_if and s2i_step.
//
// Usage: characters arrive one word per cycle on req; the word with
// start_req set carries the first character and the base (0 = auto,
// 2..36; 1 or above 36 answers at once with an empty result). Spaces and
// tabs are skipped, then an optional sign, a 0x or leading-0 prefix, and
// digits. The first character that ends the number (NUL included) yields
// one word on rsp: value, overflow, converted and end_offset. Words with
// start_req clear while no string is open are dropped without a result.
// A word taken on req is evaluated from the input register, and its
// result is written to the output register when that word advances.
// Throughput is one character per cycle while rsp is not stalled; the
// path is one 64x6 shift-add multiply with a 70-bit overflow compare.
// When rsp stalls, the input register holds one word and req.ready drops
// only once that word is also blocked. Reset empties both registers and
// leaves the parser idle, waiting for a start word.
module string_to_integer_parser
#(
    parameter int MAX_OFFSET = 255
)
(
    input  logic             clk,
    input  logic             rst_n,
    s2i_in_if.sink           req,
    s2i_out_if.source        rsp
);

    localparam int POS_W = $clog2(MAX_OFFSET + 1);

    logic             in_vld_reg;
    logic             in_start_reg;
    logic [5:0]       in_radix_reg;
    logic [7:0]       in_ch_reg;
    logic             adv;

    s2i_pkg::state_t  state_reg;
    s2i_pkg::state_t  state_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             emit;
    s2i_pkg::result_t res_next;

    logic             out_vld_reg;
    s2i_pkg::result_t res_reg;

    assign adv       = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready = !in_vld_reg || adv;

    s2i_step #(.MAX_OFFSET(MAX_OFFSET)) u_step
    (
        .start_req (in_start_reg),
        .radix     (in_radix_reg),
        .ch        (in_ch_reg),
        .st        (state_reg),
        .pos       (pos_reg),
        .st_next   (state_next),
        .pos_next  (pos_next),
        .emit      (emit),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_vld_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_start_reg <= req.start_req;
            in_radix_reg <= req.radix;
            in_ch_reg    <= req.ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase <= s2i_pkg::PH_DONE;
            state_reg.acc   <= '0;
            state_reg.neg   <= 1'b0;
            state_reg.dstat <= s2i_pkg::DS_NONE;
            state_reg.base  <= '0;
            pos_reg         <= '0;
        end
        else if (adv)
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv && emit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid      = out_vld_reg;
    assign rsp.value      = res_reg.value;
    assign rsp.overflow   = res_reg.overflow;
    assign rsp.converted  = res_reg.converted;
    assign rsp.end_offset = res_reg.end_offset;

`ifndef ASSERT_OFF
    a_empty_result : assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !res_reg.converted |->
            res_reg.value == 64'sd0 && !res_reg.overflow && res_reg.end_offset == 8'd0)
        else $error("empty result carries nonzero fields");

    a_sat_value : assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && res_reg.overflow |->
            $unsigned(res_reg.value) == s2i_pkg::VAL_MAX ||
            $unsigned(res_reg.value) == s2i_pkg::VAL_MIN)
        else $error("overflow result not saturated");

    a_pos_bound : assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_OFFSET))
        else $error("position past saturation limit");

    a_emit_idle : assert property (@(posedge clk) disable iff (!rst_n)
        adv && emit |=> state_reg.phase == s2i_pkg::PH_DONE)
        else $error("parser not idle after result");

    a_over_phase : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.dstat == s2i_pkg::DS_OVER |->
            state_reg.phase == s2i_pkg::PH_DIGITS || state_reg.phase == s2i_pkg::PH_DONE)
        else $error("overflow outside digit phase");
`endif

endmodule

// ===== bench/tb_string_to_integer_parser.sv =====
`timescale 1ns / 1ps
// Self-checking bench for string_to_integer_parser: directed table, then random strings.
// Depends on s2i_pkg and the s2i_in_if / s2i_out_if channel interfaces.
module tb_string_to_integer_parser;

    localparam int MAX_OFFSET = 255;
    localparam int ITEMS = 1000;
    localparam int CYCLE_LIMIT = 400_000;
    localparam logic [6:0] NO_DIGIT = 7'd99;
    localparam s2i_pkg::result_t NO_NUMBER = '0;

    typedef struct packed {
        logic             start;
        logic [5:0]       radix;
        logic [7:0]       ch;
        logic             typed;
        s2i_pkg::result_t want;
    } dir_row_t;

    localparam dir_row_t DIR_TABLE [28] = '{
        '{1'b0, s2i_pkg::BASE_DEC, "5", 1'b0, NO_NUMBER},
        '{1'b1, s2i_pkg::BASE_ONE, "5", 1'b1, NO_NUMBER},
        '{1'b1, 6'd37, "1", 1'b1, NO_NUMBER},
        '{1'b1, 6'd63, 8'h00, 1'b1, NO_NUMBER},
        '{1'b1, s2i_pkg::BASE_AUTO, s2i_pkg::CH_ZERO, 1'b0, NO_NUMBER},
        '{1'b0, s2i_pkg::BASE_AUTO, s2i_pkg::CH_LX, 1'b0, NO_NUMBER},
        '{1'b0, s2i_pkg::BASE_AUTO, "g", 1'b1, '{64'sd0, 1'b0, 1'b1, 8'd1}},
        '{1'b1, s2i_pkg::BASE_AUTO, s2i_pkg::CH_MINUS, 1'b0, NO_NUMBER},
        '{1'b0, 6'd63, s2i_pkg::CH_ZERO, 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, "1", 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, "7", 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, "9", 1'b0, NO_NUMBER},
        '{1'b1, s2i_pkg::BASE_DEC, s2i_pkg::CH_PLUS, 1'b0, NO_NUMBER},
        '{1'b0, s2i_pkg::BASE_DEC, 8'hFF, 1'b1, NO_NUMBER},
        '{1'b1, s2i_pkg::BASE_MAX, "z", 1'b0, NO_NUMBER},
        '{1'b0, s2i_pkg::BASE_MAX, "z", 1'b0, NO_NUMBER},
        '{1'b0, s2i_pkg::BASE_MAX, "Z", 1'b0, NO_NUMBER},
        '{1'b0, s2i_pkg::BASE_MAX, "z", 1'b0, NO_NUMBER},
        '{1'b0, s2i_pkg::BASE_MAX, "Z", 1'b0, NO_NUMBER},
        '{1'b0, s2i_pkg::BASE_MAX, "z", 1'b0, NO_NUMBER},
        '{1'b0, s2i_pkg::BASE_MAX, "z", 1'b0, NO_NUMBER},
        '{1'b0, s2i_pkg::BASE_MAX, "Z", 1'b0, NO_NUMBER},
        '{1'b0, s2i_pkg::BASE_MAX, "z", 1'b0, NO_NUMBER},
        '{1'b0, s2i_pkg::BASE_MAX, "z", 1'b0, NO_NUMBER},
        '{1'b0, s2i_pkg::BASE_MAX, "Z", 1'b0, NO_NUMBER},
        '{1'b0, s2i_pkg::BASE_MAX, "z", 1'b0, NO_NUMBER},
        '{1'b0, s2i_pkg::BASE_MAX, "z", 1'b0, NO_NUMBER},
        '{1'b0, s2i_pkg::BASE_MAX, 8'h00, 1'b1, '{s2i_pkg::VAL_MAX, 1'b1, 1'b1, 8'd13}}
    };

    logic clk = 1'b0;
    logic rst_n;

    s2i_in_if  req_ch ();
    s2i_out_if rsp_ch ();

    string_to_integer_parser #(.MAX_OFFSET(MAX_OFFSET)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [2:0]  p_phase;
    logic [63:0] p_acc;
    logic        p_neg;
    logic [1:0]  p_dstat;
    logic [5:0]  p_base;
    int unsigned p_pos;

    s2i_pkg::result_t awaited_numbers [$];
    s2i_pkg::result_t seen_num;
    s2i_pkg::result_t want_num;

    int unsigned words_parsed = 0;
    int unsigned strings_sent = 0;
    int unsigned numbers_seen = 0;
    int unsigned saturated = 0;
    int unsigned empties = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_pct = 20;
    bit quiet = 1'b0;
    bit hold_burst = 1'b0;
    bit hold_rsp_req = 1'b0;
    bit hold_served = 1'b0;
    bit rsp_calm = 1'b0;
    int unsigned stall_left = 0;

    function automatic logic [6:0] digit_value(input logic [7:0] c);
        if (c >= s2i_pkg::CH_ZERO && c <= s2i_pkg::CH_NINE)
            return 7'(c - s2i_pkg::CH_ZERO);
        if (c >= s2i_pkg::CH_UA && c <= s2i_pkg::CH_UZ)
            return 7'(c - s2i_pkg::CH_UA + 8'd10);
        if (c >= s2i_pkg::CH_LA && c <= s2i_pkg::CH_LZ)
            return 7'(c - s2i_pkg::CH_LA + 8'd10);
        return NO_DIGIT;
    endfunction

    function automatic void add_digit(input logic [6:0] d);
        logic [63:0] lim;
        lim = p_neg ? s2i_pkg::VAL_MIN : s2i_pkg::VAL_MAX;
        if (p_dstat == s2i_pkg::DS_OVER)
            return;
        if (p_acc > (lim - 64'(d)) / 64'(p_base))
            p_dstat = s2i_pkg::DS_OVER;
        else
        begin
            p_acc = p_acc * 64'(p_base) + 64'(d);
            p_dstat = s2i_pkg::DS_TAKEN;
        end
    endfunction

    function automatic s2i_pkg::result_t close_number(input bit conv, input int unsigned off);
        s2i_pkg::result_t r;
        bit ovf;
        ovf = (p_dstat == s2i_pkg::DS_OVER);
        r = NO_NUMBER;
        if (conv)
        begin
            if (ovf)
                r.value = p_neg ? s2i_pkg::VAL_MIN : s2i_pkg::VAL_MAX;
            else
                r.value = p_neg ? 64'd0 - p_acc : p_acc;
            r.overflow = ovf;
            r.converted = 1'b1;
            r.end_offset = (off > 255) ? 8'd255 : 8'(off);
        end
        p_phase = s2i_pkg::PH_DONE;
        return r;
    endfunction

    function automatic bit lead_char(input logic [7:0] c, output s2i_pkg::result_t res);
        res = NO_NUMBER;
        if (c == s2i_pkg::CH_ZERO)
        begin
            p_acc = '0;
            p_dstat = s2i_pkg::DS_TAKEN;
            p_phase = s2i_pkg::PH_ZERO;
            return 1'b0;
        end
        if (p_base == s2i_pkg::BASE_AUTO)
            p_base = s2i_pkg::BASE_DEC;
        if (digit_value(c) < 7'(p_base))
        begin
            add_digit(digit_value(c));
            p_phase = s2i_pkg::PH_DIGITS;
            return 1'b0;
        end
        res = close_number(1'b0, 0);
        return 1'b1;
    endfunction

    function automatic bit parse_char(input bit s, input logic [5:0] r, input logic [7:0] c,
                                      output s2i_pkg::result_t res);
        logic [6:0] d;
        bit out;
        d = digit_value(c);
        out = 1'b0;
        res = NO_NUMBER;
        if (s)
        begin
            p_phase = s2i_pkg::PH_SPACE;
            p_acc = '0;
            p_neg = 1'b0;
            p_dstat = s2i_pkg::DS_NONE;
            p_base = r;
            p_pos = 0;
            if (r == s2i_pkg::BASE_ONE || r > s2i_pkg::BASE_MAX)
            begin
                res = close_number(1'b0, 0);
                return 1'b1;
            end
        end
        case (p_phase)
            s2i_pkg::PH_SPACE:
                if (c != s2i_pkg::CH_SPACE && c != s2i_pkg::CH_TAB)
                begin
                    if (c == s2i_pkg::CH_PLUS || c == s2i_pkg::CH_MINUS)
                    begin
                        p_neg = (c == s2i_pkg::CH_MINUS);
                        p_phase = s2i_pkg::PH_SIGNED;
                    end
                    else
                        out = lead_char(c, res);
                end
            s2i_pkg::PH_SIGNED:
                out = lead_char(c, res);
            s2i_pkg::PH_ZERO:
                if ((p_base == s2i_pkg::BASE_AUTO || p_base == s2i_pkg::BASE_HEX) &&
                    (c == s2i_pkg::CH_LX || c == s2i_pkg::CH_UX))
                begin
                    p_base = s2i_pkg::BASE_HEX;
                    p_phase = s2i_pkg::PH_XPFX;
                end
                else
                begin
                    if (p_base == s2i_pkg::BASE_AUTO)
                        p_base = s2i_pkg::BASE_OCT;
                    if (d < 7'(p_base))
                    begin
                        add_digit(d);
                        p_phase = s2i_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        res = close_number(1'b1, p_pos);
                        out = 1'b1;
                    end
                end
            s2i_pkg::PH_XPFX:
                if (d < 7'(p_base))
                begin
                    add_digit(d);
                    p_phase = s2i_pkg::PH_DIGITS;
                end
                else
                begin
                    res = close_number(1'b1, (p_pos > 0) ? p_pos - 1 : 0);
                    out = 1'b1;
                end
            s2i_pkg::PH_DIGITS:
                if (d < 7'(p_base))
                    add_digit(d);
                else
                begin
                    res = close_number(1'b1, p_pos);
                    out = 1'b1;
                end
            default:
                return 1'b0;
        endcase
        if (p_pos < MAX_OFFSET)
            p_pos++;
        return out;
    endfunction

    function automatic logic [7:0] digit_char(input int unsigned d);
        if (d < 10)
            return s2i_pkg::CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? s2i_pkg::CH_UA : s2i_pkg::CH_LA) + 8'(d - 10);
    endfunction

    task automatic send_word(input bit s, input logic [5:0] r, input logic [7:0] c,
                             input bit typed, input s2i_pkg::result_t want);
        int unsigned gap;
        s2i_pkg::result_t res;
        bit got;
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 12);
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.start_req = s;
        req_ch.radix = r;
        req_ch.ch = c;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (s || p_phase != s2i_pkg::PH_DONE)
            words_parsed++;
        got = parse_char(s, r, c, res);
        if (typed)
            awaited_numbers.push_back(want);
        else if (got)
            awaited_numbers.push_back(res);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (awaited_numbers.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_string(input int unsigned pad);
        logic [7:0] text [$];
        int unsigned digs [$];
        logic [5:0] base;
        logic [63:0] mag;
        int unsigned eff;
        int unsigned pick;
        bit s;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            base = s2i_pkg::BASE_AUTO;
        else if (pick < 38)
            base = s2i_pkg::BASE_DEC;
        else if (pick < 50)
            base = s2i_pkg::BASE_HEX;
        else if (pick < 58)
            base = s2i_pkg::BASE_OCT;
        else if (pick < 64)
            base = 6'd2;
        else if (pick < 72)
            base = s2i_pkg::BASE_MAX;
        else if (pick < 92)
            base = 6'($urandom_range(2, 36));
        else
            base = ($urandom_range(0, 3) == 0) ? s2i_pkg::BASE_ONE : 6'($urandom_range(37, 63));
        gap_pct = (quiet || hold_burst || $urandom_range(0, 3) == 0) ? 0 : 20;

        repeat (pad) text.push_back(s2i_pkg::CH_SPACE);
        repeat ($urandom_range(0, 3))
            text.push_back($urandom_range(0, 1) ? s2i_pkg::CH_SPACE : s2i_pkg::CH_TAB);
        pick = $urandom_range(0, 2);
        if (pick == 1)
            text.push_back(s2i_pkg::CH_PLUS);
        else if (pick == 2)
            text.push_back(s2i_pkg::CH_MINUS);

        eff = (base == s2i_pkg::BASE_AUTO || base == s2i_pkg::BASE_ONE ||
               base > s2i_pkg::BASE_MAX) ? 10 : base;
        pick = $urandom_range(0, 9);
        if ((base == s2i_pkg::BASE_AUTO || base == s2i_pkg::BASE_HEX) && pick < 3)
        begin
            text.push_back(s2i_pkg::CH_ZERO);
            text.push_back($urandom_range(0, 1) ? s2i_pkg::CH_LX : s2i_pkg::CH_UX);
            eff = 16;
        end
        else if (pick < 5)
        begin
            text.push_back(s2i_pkg::CH_ZERO);
            if (base == s2i_pkg::BASE_AUTO)
                eff = 8;
        end

        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            case ($urandom_range(0, 3))
                0: mag = s2i_pkg::VAL_MAX - 64'($urandom_range(0, 2));
                1: mag = s2i_pkg::VAL_MIN;
                2: mag = s2i_pkg::VAL_MIN + 64'($urandom_range(1, 2));
                default: mag = {$urandom, $urandom};
            endcase
            do
            begin
                digs.push_front(int'(mag % 64'(eff)));
                mag = mag / 64'(eff);
            end
            while (mag != 0);
            foreach (digs[i])
                text.push_back(digit_char(digs[i]));
        end
        else
        begin
            repeat ((pick < 3) ? $urandom_range(9, 70) : $urandom_range(0, 8))
                text.push_back(digit_char($urandom_range(0, eff - 1)));
        end

        pick = $urandom_range(0, 9);
        if (pick < 4)
            text.push_back(8'h00);
        else if (pick < 7)
            text.push_back($urandom_range(0, 1) ? 8'($urandom_range(128, 255))
                                                : s2i_pkg::CH_PLUS);
        else
            text.push_back(8'($urandom_range(0, 255)));

        if (pad == 0 && $urandom_range(0, 9) == 0)
        begin
            text.delete();
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
        end

        foreach (text[i])
        begin
            s = (i == 0) || ($urandom_range(0, 63) == 0);
            send_word(s, (i == 0) ? base : 6'($urandom_range(0, 63)), text[i], 1'b0, NO_NUMBER);
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                send_word(1'b0, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                          1'b0, NO_NUMBER);
        strings_sent++;
    endtask

    task automatic flag_bad(input string what, input s2i_pkg::result_t want,
                            input s2i_pkg::result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected value %0d ovf %0b conv %0b off %0d, %s %0d %s %0b %s %0b %s %0d",
                     what, want.value, want.overflow, want.converted, want.end_offset,
                     "got value", got.value, "ovf", got.overflow, "conv", got.converted,
                     "off", got.end_offset);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen_num.value = rsp_ch.value;
            seen_num.overflow = rsp_ch.overflow;
            seen_num.converted = rsp_ch.converted;
            seen_num.end_offset = rsp_ch.end_offset;
            numbers_seen++;
            if (seen_num.overflow)
                saturated++;
            if (!seen_num.converted)
                empties++;
            if (awaited_numbers.size() == 0)
                flag_bad("unexpected number", NO_NUMBER, seen_num);
            else
            begin
                want_num = awaited_numbers.pop_front();
                if (seen_num.value !== want_num.value || seen_num.overflow !== want_num.overflow
                    || seen_num.converted !== want_num.converted
                    || seen_num.end_offset !== want_num.end_offset)
                    flag_bad("mismatch", want_num, seen_num);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rsp_req && !hold_served)
            begin
                hold_served = 1'b1;
                rsp_ch.ready = 1'b0;
                repeat (300) @(negedge clk);
            end
            else if (stall_left > 0 && !quiet)
            begin
                stall_left--;
                rsp_ch.ready = 1'b0;
            end
            else if (!quiet && !rsp_calm && $urandom_range(0, 99) < 10)
            begin
                stall_left = $urandom_range(0, 11);
                rsp_ch.ready = 1'b0;
            end
            else
                rsp_ch.ready = 1'b1;
            if ($urandom_range(0, 199) == 0)
                rsp_calm = !rsp_calm;
        end
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.start_req = 1'b0;
        req_ch.radix = '0;
        req_ch.ch = '0;
        rst_n = 1'b0;
        p_phase = s2i_pkg::PH_DONE;
        p_acc = '0;
        p_neg = 1'b0;
        p_dstat = s2i_pkg::DS_NONE;
        p_base = '0;
        p_pos = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < $size(DIR_TABLE); i++)
            send_word(DIR_TABLE[i].start, DIR_TABLE[i].radix, DIR_TABLE[i].ch,
                      DIR_TABLE[i].typed, DIR_TABLE[i].want);

        while (words_parsed < ITEMS)
        begin
            if (strings_sent == 15)
                wait_drained();
            hold_burst = (strings_sent >= 20 && strings_sent < 32);
            if (hold_burst)
                hold_rsp_req = 1'b1;
            if (words_parsed > ITEMS * 85 / 100)
                quiet = 1'b1;
            send_string((strings_sent == 10) ? 260 : 0);
        end

        wait_drained();
        repeat (8) @(negedge clk);
        $display("Sent %0d strings (%0d parsed words); %0d numbers back, %0d saturated, %0d empty.",
                 strings_sent, words_parsed, numbers_seen, saturated, empties);
        $display("Mismatches: %0d, numbers still awaited: %0d.", mismatches,
                 awaited_numbers.size());
        if (mismatches == 0 && awaited_numbers.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
